/* rtl/tlnf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlnf_pkg: shared types and constants of the text line-numbering filter
// Character codes, register indexes and the per-item run flags.
// ----------------------------------------------------------------------------
package tlnf_pkg;

	localparam int TLNF_NUMBER_DIGITS = 6;
	localparam int CAP_DIGITS_MAX     = 6;
	localparam int CFG_IDX_W          = 3;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_UPPER_I = 8'h49;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CARET_OFS = 8'h40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUMBER_ALL      = 3'd0,
		CFG_NUMBER_NONBLANK = 3'd1,
		CFG_SQUEEZE         = 3'd2,
		CFG_SHOW_ENDS       = 3'd3,
		CFG_SHOW_TABS       = 3'd4,
		CFG_SHOW_NONPRINT   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic num;
		logic dollar;
		logic caret;
	} run_flags_t;

endpackage
`default_nettype wire

/* rtl/tlnf_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlnf_front: option registers, line history and BCD line counter
// Works out what one accepted byte produces and updates the history.
// ----------------------------------------------------------------------------
module tlnf_front #(
	parameter int NUMBER_DIGITS = tlnf_pkg::TLNF_NUMBER_DIGITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                           cfg_data,
	input  wire logic                           accept,
	input  wire logic [7:0]                     in_byte,
	input  wire logic                           new_file,
	output logic                                load,
	output tlnf_pkg::run_flags_t                flags,
	output logic [7:0]                          fch,
	output logic [NUMBER_DIGITS-1:0][3:0]       dig,
	output logic [NUMBER_DIGITS-1:0]            blank
);
	import tlnf_pkg::*;

	localparam int CAP_DIGITS = (NUMBER_DIGITS < CAP_DIGITS_MAX) ? NUMBER_DIGITS
		: CAP_DIGITS_MAX;

	logic number_all_q, number_nonblank_q, squeeze_q, show_ends_q;
	logic show_tabs_q, show_nonprint_q;
	logic prev_nl_q, prev2_nl_q, at_start_q;
	logic [NUMBER_DIGITS-1:0][3:0] cnt_q;

	logic pn, ppn, ats, pn_n, ppn_n, ats_n;
	logic is_nl, is_tab, squeezed, emit_num, num_on, carry, at_max, zero_run;
	logic [NUMBER_DIGITS-1:0][3:0] cnt_e, cnt_inc, cnt_n;

	always_comb begin
		pn     = new_file ? 1'b0 : prev_nl_q;
		ppn    = new_file ? 1'b0 : prev2_nl_q;
		ats    = new_file ? 1'b1 : at_start_q;
		cnt_e  = new_file ? '0 : cnt_q;
		is_nl  = (in_byte == CH_NL);
		is_tab = (in_byte == CH_TAB);

		squeezed = squeeze_q && is_nl && pn && ppn;
		pn_n     = squeeze_q ? is_nl : pn;
		ppn_n    = (squeeze_q && !squeezed) ? pn : ppn;

		num_on   = number_all_q | number_nonblank_q;
		emit_num = !squeezed && (number_nonblank_q ? (ats && !is_nl)
			: (number_all_q && ats));
		ats_n    = (!squeezed && num_on) ? (is_nl | (ats & ~emit_num)) : ats;

		at_max = 1'b1;
		for (int k = 0; k < CAP_DIGITS; k++) begin
			at_max = at_max & (cnt_e[k] == 4'd9);
		end
		carry   = !at_max;
		cnt_inc = cnt_e;
		for (int k = 0; k < CAP_DIGITS; k++) begin
			if (carry) begin
				cnt_inc[k] = (cnt_e[k] == 4'd9) ? 4'd0 : cnt_e[k] + 4'd1;
			end
			carry = carry & (cnt_e[k] == 4'd9);
		end
		cnt_n = emit_num ? cnt_inc : cnt_e;

		zero_run = 1'b1;
		for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
			zero_run = zero_run & (cnt_n[k] == 4'd0);
			blank[k] = zero_run & (k != 0);
		end
		dig = cnt_n;

		flags.num    = emit_num;
		flags.dollar = show_ends_q && is_nl;
		flags.caret  = 1'b0;
		fch          = in_byte;
		if (show_tabs_q && is_tab) begin
			flags.caret = 1'b1;
			fch         = CH_UPPER_I;
		end else if (show_nonprint_q && in_byte <= CH_CTRL_MAX && !is_nl && !is_tab) begin
			flags.caret = 1'b1;
			fch         = in_byte + CARET_OFS;
		end else if (show_nonprint_q && in_byte == CH_DEL) begin
			flags.caret = 1'b1;
			fch         = CH_QMARK;
		end

		load = accept && !squeezed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_all_q      <= 1'b0;
			number_nonblank_q <= 1'b0;
			squeeze_q         <= 1'b0;
			show_ends_q       <= 1'b0;
			show_tabs_q       <= 1'b0;
			show_nonprint_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUMBER_ALL:      number_all_q      <= cfg_data;
				CFG_NUMBER_NONBLANK: number_nonblank_q <= cfg_data;
				CFG_SQUEEZE:         squeeze_q         <= cfg_data;
				CFG_SHOW_ENDS:       show_ends_q       <= cfg_data;
				CFG_SHOW_TABS:       show_tabs_q       <= cfg_data;
				CFG_SHOW_NONPRINT:   show_nonprint_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_nl_q  <= 1'b0;
			prev2_nl_q <= 1'b0;
			at_start_q <= 1'b1;
			cnt_q      <= '0;
		end else if (accept) begin
			prev_nl_q  <= pn_n;
			prev2_nl_q <= ppn_n;
			at_start_q <= ats_n;
			cnt_q      <= cnt_n;
		end
	end

endmodule
`default_nettype wire

/* rtl/tlnf_emit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlnf_emit: run register and output byte sequencer
// Holds one item's run and sends its bytes, one per transfer, via an output register.
// ----------------------------------------------------------------------------
module tlnf_emit #(
	parameter int NUMBER_DIGITS = tlnf_pkg::TLNF_NUMBER_DIGITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           load,
	input  tlnf_pkg::run_flags_t                flags,
	input  wire logic [7:0]                     fch,
	input  wire logic [NUMBER_DIGITS-1:0][3:0]  dig,
	input  wire logic [NUMBER_DIGITS-1:0]       blank,
	output logic                                s1_free,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic                                last_of_run
);
	import tlnf_pkg::*;

	localparam int POS_W = $clog2(NUMBER_DIGITS + 4);
	localparam logic [POS_W-1:0] POS_FIRST  = '0;
	localparam logic [POS_W-1:0] POS_TAB    = POS_W'(NUMBER_DIGITS);
	localparam logic [POS_W-1:0] POS_DOLLAR = POS_W'(NUMBER_DIGITS + 1);
	localparam logic [POS_W-1:0] POS_CARET  = POS_W'(NUMBER_DIGITS + 2);
	localparam logic [POS_W-1:0] POS_CHAR   = POS_W'(NUMBER_DIGITS + 3);

	run_flags_t                    flags_s1;
	logic [7:0]                    fch_s1;
	logic [NUMBER_DIGITS-1:0][3:0] dig_s1;
	logic [NUMBER_DIGITS-1:0]      blank_s1;
	logic                          v_s1;
	logic [POS_W-1:0]              pos_q;
	logic                          o_valid_q, last_q;
	logic [7:0]                    o_byte_q;

	logic       o_load, fin;
	logic [7:0] cur;

	function automatic logic [POS_W-1:0] after_dollar(input run_flags_t f);
		after_dollar = f.caret ? POS_CARET : POS_CHAR;
	endfunction

	function automatic logic [POS_W-1:0] after_tab(input run_flags_t f);
		after_tab = f.dollar ? POS_DOLLAR : after_dollar(f);
	endfunction

	function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
			input run_flags_t f);
		if (p < POS_TAB) begin
			step_pos = (p == POS_TAB - 1'b1) ? POS_TAB : p + 1'b1;
		end else if (p == POS_TAB) begin
			step_pos = after_tab(f);
		end else if (p == POS_DOLLAR) begin
			step_pos = after_dollar(f);
		end else begin
			step_pos = POS_CHAR;
		end
	endfunction

	always_comb begin
		cur = fch_s1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (pos_q == POS_W'(i)) begin
				cur = blank_s1[NUMBER_DIGITS-1-i] ? CH_SPACE
					: (CH_ZERO | {4'h0, dig_s1[NUMBER_DIGITS-1-i]});
			end
		end
		if (pos_q == POS_TAB) begin
			cur = CH_TAB;
		end else if (pos_q == POS_DOLLAR) begin
			cur = CH_DOLLAR;
		end else if (pos_q == POS_CARET) begin
			cur = CH_CARET;
		end
		fin     = (pos_q == POS_CHAR);
		o_load  = v_s1 && (!o_valid_q || !out_stall);
		s1_free = !v_s1 || (o_load && fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			pos_q     <= POS_FIRST;
			o_valid_q <= 1'b0;
		end else begin
			if (load) begin
				v_s1  <= 1'b1;
				pos_q <= flags.num ? POS_FIRST : after_tab(flags);
			end else if (o_load) begin
				if (fin) begin
					v_s1 <= 1'b0;
				end
				pos_q <= step_pos(pos_q, flags_s1);
			end
			if (o_load) begin
				o_valid_q <= 1'b1;
			end else if (!out_stall) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			flags_s1 <= flags;
			fch_s1   <= fch;
			dig_s1   <= dig;
			blank_s1 <= blank;
		end
		if (o_load) begin
			o_byte_q <= cur;
			last_q   <= fin;
		end
	end

	assign out_valid   = o_valid_q;
	assign out_byte    = o_byte_q;
	assign last_of_run = last_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> pos_q <= POS_CHAR)
		else $error("run position out of range");

	a_digits_need_num: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && pos_q <= POS_TAB |-> flags_s1.num)
		else $error("number field sent without numbering");

	a_dollar_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && pos_q == POS_DOLLAR |-> flags_s1.dollar)
		else $error("dollar sent without line-end flag");

	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		o_load |=> last_q == $past(fin))
		else $error("last_of_run does not match run end");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> s1_free)
		else $error("run register overwritten");

endmodule
`default_nettype wire

/* rtl/text_line_numbering_filter.sv */
// An accepted byte is held in the run register; each of its output bytes is sent through the output register.
// Throughput: one input byte per cycle while each byte yields one output byte and
// the output is not stalled; a byte that yields k bytes (up to NUMBER_DIGITS + 3)
// holds the run register until its last byte is sent. Squeezed newlines are accepted but give no output.
// Reset: all options off, line count zero, history cleared, at start of line.
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_numbering_filter: byte stream rewriter with line numbers
// Squeezes blank lines, numbers lines and shows tabs, ends and control bytes.
// ----------------------------------------------------------------------------
module text_line_numbering_filter #(
	parameter int NUMBER_DIGITS = tlnf_pkg::TLNF_NUMBER_DIGITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     in_byte,
	input  wire logic                           new_file,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic                                last_of_run,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                           cfg_data
);
	import tlnf_pkg::*;

	logic                          accept, load, s1_free;
	run_flags_t                    flags;
	logic [7:0]                    fch;
	logic [NUMBER_DIGITS-1:0][3:0] dig;
	logic [NUMBER_DIGITS-1:0]      blank;

	assign cfg_ready = 1'b1;
	assign in_stall  = !s1_free;
	assign accept    = in_valid && s1_free;

	tlnf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.in_byte  (in_byte),
		.new_file (new_file),
		.load     (load),
		.flags    (flags),
		.fch      (fch),
		.dig      (dig),
		.blank    (blank)
	);

	tlnf_emit #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.flags      (flags),
		.fch        (fch),
		.dig        (dig),
		.blank      (blank),
		.s1_free    (s1_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule
`default_nettype wire

/* dv/tb_text_line_numbering_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_line_numbering_filter: self-checking bench of the line filter
// Drives byte transfers under random idling and back-pressure and predicts
// each output byte from its own model of the options, line count and
// newline history.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [7:0] ch;
	logic       last;
} out_beat_t;

class text_filter_sb;
	bit num_all, num_nonblank, squeeze, show_ends, show_tabs, show_nonprint;
	bit prev_nl, prev2_nl;
	bit at_line_start = 1'b1;
	int unsigned line_no;
	out_beat_t expected_out[$];
	int errors;

	function void write_reg(tlnf_pkg::cfg_idx_t idx, bit v);
		case (idx)
			tlnf_pkg::CFG_NUMBER_ALL:      num_all = v;
			tlnf_pkg::CFG_NUMBER_NONBLANK: num_nonblank = v;
			tlnf_pkg::CFG_SQUEEZE:         squeeze = v;
			tlnf_pkg::CFG_SHOW_ENDS:       show_ends = v;
			tlnf_pkg::CFG_SHOW_TABS:       show_tabs = v;
			tlnf_pkg::CFG_SHOW_NONPRINT:   show_nonprint = v;
			default: ;
		endcase
	endfunction

	function void put(logic [7:0] ch);
		expected_out.push_back('{ch, 1'b0});
	endfunction

	function void put_line_number();
		logic [7:0] digits [tlnf_pkg::TLNF_NUMBER_DIGITS];
		longint cap;
		int unsigned v;
		cap = 1;
		for (int i = 0; i < tlnf_pkg::TLNF_NUMBER_DIGITS; i++)
			cap *= 10;
		cap = cap - 1;
		if (cap > 999999)
			cap = 999999;
		if (line_no < cap)
			line_no++;
		v = line_no;
		for (int i = tlnf_pkg::TLNF_NUMBER_DIGITS - 1; i >= 0; i--) begin
			if (v != 0 || i == tlnf_pkg::TLNF_NUMBER_DIGITS - 1) begin
				digits[i] = tlnf_pkg::CH_ZERO + 8'(v % 10);
				v = v / 10;
			end else begin
				digits[i] = tlnf_pkg::CH_SPACE;
			end
		end
		for (int i = 0; i < tlnf_pkg::TLNF_NUMBER_DIGITS; i++)
			put(digits[i]);
		put(tlnf_pkg::CH_TAB);
	endfunction

	function void take_byte(logic [7:0] ch, logic nf);
		bit is_nl;
		bit dropped;
		is_nl = (ch == tlnf_pkg::CH_NL);
		dropped = 1'b0;
		if (nf) begin
			prev_nl = 1'b0;
			prev2_nl = 1'b0;
			line_no = 0;
			at_line_start = 1'b1;
		end
		if (squeeze) begin
			dropped = is_nl && prev_nl && prev2_nl;
			if (!dropped)
				prev2_nl = prev_nl;
			prev_nl = is_nl;
		end
		if (dropped)
			return;
		if (num_nonblank) begin
			if (at_line_start && !is_nl) begin
				put_line_number();
				at_line_start = 1'b0;
			end
			if (is_nl)
				at_line_start = 1'b1;
		end else if (num_all) begin
			if (at_line_start) begin
				put_line_number();
				at_line_start = 1'b0;
			end
			if (is_nl)
				at_line_start = 1'b1;
		end
		if (show_ends && is_nl)
			put(tlnf_pkg::CH_DOLLAR);
		if (show_tabs && ch == tlnf_pkg::CH_TAB) begin
			put(tlnf_pkg::CH_CARET);
			put(tlnf_pkg::CH_UPPER_I);
		end else if (show_nonprint && ch <= tlnf_pkg::CH_CTRL_MAX && !is_nl
				&& ch != tlnf_pkg::CH_TAB) begin
			put(tlnf_pkg::CH_CARET);
			put(ch + tlnf_pkg::CARET_OFS);
		end else if (show_nonprint && ch == tlnf_pkg::CH_DEL) begin
			put(tlnf_pkg::CH_CARET);
			put(tlnf_pkg::CH_QMARK);
		end else begin
			put(ch);
		end
		expected_out[expected_out.size() - 1].last = 1'b1;
	endfunction

	function void check_out(logic [7:0] ch, logic last);
		out_beat_t want;
		if (expected_out.size() == 0) begin
			errors++;
			$display("%0t: unexpected transfer, expected none, actual byte %h last %b",
				$time, ch, last);
			return;
		end
		want = expected_out.pop_front();
		if (ch !== want.ch) begin
			errors++;
			$display("%0t: out_byte expected %h actual %h", $time, want.ch, ch);
		end
		if (last !== want.last) begin
			errors++;
			$display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
		end
	endfunction

	function int pending();
		return expected_out.size();
	endfunction
endclass

module tb_text_line_numbering_filter;
	import tlnf_pkg::*;

	localparam int QUIET_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE       = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 60;

	typedef struct packed {
		bit nonprint;
		bit tabs;
		bit ends;
		bit squeeze;
		bit nonblank;
		bit all;
	} opts_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	logic [7:0]     in_byte;
	logic           new_file;
	logic           out_valid;
	logic           out_stall;
	logic [7:0]     out_byte;
	logic           last_of_run;
	logic           cfg_valid;
	logic           cfg_ready;
	cfg_idx_t       cfg_index;
	logic           cfg_data;

	text_filter_sb  sb;
	bit             idle_en = 1'b1;
	bit             hold_req = 1'b0;
	int             quiet_cycles = 0;

	text_line_numbering_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.new_file   (new_file),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_byte(in_byte, new_file);
			if (out_valid && !out_stall)
				sb.check_out(out_byte, last_of_run);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAIL text_line_numbering_filter");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic nf);
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte <= b;
		new_file <= nf;
		do @(posedge clk); while (in_stall);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9) - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_opts(input opts_t o);
		write_reg(CFG_NUMBER_ALL, o.all);
		write_reg(CFG_NUMBER_NONBLANK, o.nonblank);
		write_reg(CFG_SQUEEZE, o.squeeze);
		write_reg(CFG_SHOW_ENDS, o.ends);
		write_reg(CFG_SHOW_TABS, o.tabs);
		write_reg(CFG_SHOW_NONPRINT, o.nonprint);
	endtask

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 8'($urandom_range(8'h20, 8'h7E));
		else if (r < 70)
			return CH_NL;
		else if (r < 76)
			return CH_TAB;
		else if (r < 85)
			return 8'($urandom_range(0, 31));
		else if (r < 88)
			return CH_DEL;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		opts_t opts;
		int sent;
		sb = new;
		in_valid = 1'b0;
		in_byte = 8'h00;
		new_file = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NUMBER_ALL;
		cfg_data = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset options: everything passes through
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_DEL, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(8'h41, 1'b0);

		// every option on: nonblank numbering wins, blank runs squeezed
		drain();
		apply_opts('1);
		send_item(8'h41, 1'b1);
		send_item(CH_TAB, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(CH_CTRL_MAX, 1'b0);
		send_item(CH_DEL, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(8'h62, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(CH_NL, 1'b1);

		// all-line numbering with line ends shown
		drain();
		opts = '0;
		opts.all = 1'b1;
		opts.ends = 1'b1;
		apply_opts(opts);
		send_item(CH_NL, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(8'h78, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_item(CH_NL, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				opts = '1;
			else if (p == 1)
				opts = '0;
			else
				opts = opts_t'(6'($urandom));
			if (p == 2)
				opts.all = 1'b1;
			if (p == PHASES - 1)
				idle_en = 1'b0;
			drain();
			apply_opts(opts);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (p == 2 && sent == 10)
					hold_req = 1'b1;
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(2, 5)) begin
						send_item(CH_NL, 1'b0);
						sent++;
					end
				end else begin
					send_item(pick_byte(), $urandom_range(0, 39) == 0);
					sent++;
				end
			end
		end
		drain();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS text_line_numbering_filter");
		else
			$display("FAIL text_line_numbering_filter");
		$finish;
	end

endmodule

/* text_line_numbering_filter.f */
rtl/tlnf_pkg.sv
rtl/tlnf_front.sv
rtl/tlnf_emit.sv
rtl/text_line_numbering_filter.sv
dv/tb_text_line_numbering_filter.sv
